FILE: src/gea_pkg.sv
// ----------------------------------------------------------------------------
// gea_pkg
// shared widths, fixed-point constants and the arctangent table for the
// elevation angle pipeline
// ----------------------------------------------------------------------------
package gea_pkg;

   // payload field widths
   localparam int LAT_W  = 31;
   localparam int LON_W  = 32;
   localparam int ALT_W  = 25;
   localparam int TILT_W = 15;
   localparam int DIST_W = 26;

   localparam int CORDIC_STAGES_DEFAULT = 16;

   // internal datapath widths
   localparam int CX_W = 34;   // cosine rotation x/y, q30
   localparam int CZ_W = 36;   // angles, q32 radians
   localparam int AX_W = 62;   // vectoring x/y, centimetres q24

   // fixed-point constants
   localparam logic [CZ_W-1:0] PI_Q32        = 36'd13493037705;
   localparam logic [CZ_W-1:0] HALF_PI_Q32   = 36'd6746518852;
   localparam logic [CZ_W-1:0] QUARTER_PI_Q32 = 36'd3373259426;
   localparam logic [29:0]     LATSUM_TO_RAD = 30'd1006113814;
   localparam logic [CX_W-1:0] INV_GAIN_Q30  = 34'd652032874;
   localparam logic [25:0]     KM_Q32        = 26'd47757857;
   localparam logic [24:0]     KCM_Q24       = 25'd18655413;
   localparam logic [28:0]     DEG100_Q16    = 29'd375493621;
   localparam logic [DIST_W-1:0] DIST_MAX    = 26'd45000000;
   localparam logic [TILT_W-1:0] ANGLE_MAX   = 15'd9000;

   // arctangent of 2^-i in q32 radians
   function automatic logic signed [CZ_W-1:0] atan_q32(input logic [4:0] i);
      logic [5:0]      sh;
      logic [CZ_W-1:0] r;
      sh = 6'd32 - {1'b0, i};
      unique case (i)
         5'd0:  r = QUARTER_PI_Q32;
         5'd1:  r = 36'd1991351318;
         5'd2:  r = 36'd1052175346;
         5'd3:  r = 36'd534100635;
         5'd4:  r = 36'd268086748;
         5'd5:  r = 36'd134174063;
         5'd6:  r = 36'd67103403;
         5'd7:  r = 36'd33553749;
         5'd8:  r = 36'd16777131;
         5'd9:  r = 36'd8388597;
         5'd10: r = 36'd4194303;
         default: r = 36'd1 << sh;
      endcase
      return $signed(r);
   endfunction

endpackage

FILE: src/gea_ifs.sv
// ----------------------------------------------------------------------------
// gea channel interfaces
// valid/ready channels for point pairs and angle results
// ----------------------------------------------------------------------------
interface gea_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [gea_pkg::LAT_W-1:0]   lat_a;
   logic signed [gea_pkg::LON_W-1:0]   lon_a;
   logic signed [gea_pkg::ALT_W-1:0]   alt_a;
   logic signed [gea_pkg::LAT_W-1:0]   lat_b;
   logic signed [gea_pkg::LON_W-1:0]   lon_b;
   logic signed [gea_pkg::ALT_W-1:0]   alt_b;

   modport source (output valid, lat_a, lon_a, alt_a, lat_b, lon_b, alt_b, input ready);
   modport sink   (input valid, lat_a, lon_a, alt_a, lat_b, lon_b, alt_b, output ready);
endinterface

interface gea_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [gea_pkg::TILT_W-1:0]  tilt_angle;
   logic        [gea_pkg::DIST_W-1:0]  ground_distance;

   modport source (output valid, tilt_angle, ground_distance, input ready);
   modport sink   (input valid, tilt_angle, ground_distance, output ready);
endinterface

FILE: src/gps_elevation_angle.sv
// throughput: one point pair per cycle while rsp is ready; each stage advances when it is
//   empty or the stage after it advances, so bubbles collapse while rsp is stalled
// reset: synchronous, clears all stage valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// gps_elevation_angle
// climb angle and equirectangular ground distance between two gps points,
// fully pipelined: cosine cordic, square root, vectoring cordic
// ----------------------------------------------------------------------------
module gps_elevation_angle #(
   parameter int CORDIC_STAGES = gea_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   gea_req_if.sink      req,
   gea_rsp_if.source    rsp
);

   localparam int S   = CORDIC_STAGES;
   localparam int CXW = gea_pkg::CX_W;
   localparam int CZW = gea_pkg::CZ_W;
   localparam int AXW = gea_pkg::AX_W;

   // stage positions along the pipe
   localparam int P0     = 0;
   localparam int P1     = 1;
   localparam int P2     = 2;
   localparam int C_BASE = 3;
   localparam int ACS    = S + 3;
   localparam int AXS    = S + 4;
   localparam int HKS    = S + 5;
   localparam int SQS    = S + 6;
   localparam int SUMS   = S + 7;
   localparam int R_BASE = S + 8;
   localparam int HHS    = S + 40;
   localparam int MPS    = S + 41;
   localparam int DXS    = S + 42;
   localparam int A_BASE = S + 43;
   localparam int ZPS    = 2*S + 43;
   localparam int OUTS   = 2*S + 44;
   localparam int NS     = 2*S + 45;

   // ---------------------------------------------------------------- flow control
   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp.ready;
      for (int k = NS-2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req.valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign req.ready = en[0];

   // ---------------------------------------------------------------- p0: differences
   logic        [31:0] p0_lsum_ff;
   logic        [32:0] p0_dlon_ff;
   logic        [31:0] p0_dlat_ff;
   logic signed [25:0] p0_dalt_ff;

   logic signed [31:0] lsum_in;
   logic signed [32:0] dlon_in;
   logic signed [31:0] dlat_in;

   assign lsum_in = {req.lat_a[30], req.lat_a} + {req.lat_b[30], req.lat_b};
   assign dlon_in = {req.lon_b[31], req.lon_b} - {req.lon_a[31], req.lon_a};
   assign dlat_in = {req.lat_b[30], req.lat_b} - {req.lat_a[30], req.lat_a};

   always_ff @(posedge clock) begin
      if (en[P0]) begin
         p0_lsum_ff <= lsum_in[31] ? 32'(-lsum_in) : 32'(lsum_in);
         p0_dlon_ff <= dlon_in[32] ? 33'(-dlon_in) : 33'(dlon_in);
         p0_dlat_ff <= dlat_in[31] ? 32'(-dlat_in) : 32'(dlat_in);
         p0_dalt_ff <= {req.alt_b[24], req.alt_b} - {req.alt_a[24], req.alt_a};
      end
   end

   // ---------------------------------------------------------------- p1: mean latitude to radians
   logic        [33:0] p1_zraw_ff;
   logic        [32:0] p1_dlon_ff;
   logic        [31:0] p1_dlat_ff;
   logic signed [25:0] p1_dalt_ff;
   logic        [61:0] lrad_prod;

   assign lrad_prod = {30'd0, p0_lsum_ff} * {32'd0, gea_pkg::LATSUM_TO_RAD};

   always_ff @(posedge clock) begin
      if (en[P1]) begin
         p1_zraw_ff <= 34'((lrad_prod + 62'd134217728) >> 28);
         p1_dlon_ff <= p0_dlon_ff;
         p1_dlat_ff <= p0_dlat_ff;
         p1_dalt_ff <= p0_dalt_ff;
      end
   end

   // ---------------------------------------------------------------- p2: fold above pi/2
   // sign of the cosine is dropped later, only its magnitude is used
   logic signed [CZW-1:0] p2_z_ff;
   logic        [32:0]    p2_dlon_ff;
   logic        [31:0]    p2_dlat_ff;
   logic signed [25:0]    p2_dalt_ff;

   always_ff @(posedge clock) begin
      if (en[P2]) begin
         if ({2'd0, p1_zraw_ff} > gea_pkg::HALF_PI_Q32) begin
            p2_z_ff <= $signed(gea_pkg::PI_Q32 - {2'd0, p1_zraw_ff});
         end else begin
            p2_z_ff <= $signed({2'd0, p1_zraw_ff});
         end
         p2_dlon_ff <= p1_dlon_ff;
         p2_dlat_ff <= p1_dlat_ff;
         p2_dalt_ff <= p1_dalt_ff;
      end
   end

   // ---------------------------------------------------------------- cosine cordic (rotation)
   logic signed [CXW-1:0] cx_ff    [S];
   logic signed [CXW-1:0] cy_ff    [S];
   logic signed [CZW-1:0] cz_ff    [S];
   logic        [32:0]    cdlon_ff [S];
   logic        [31:0]    cdlat_ff [S];
   logic signed [25:0]    cdalt_ff [S];

   for (genvar i = 0; i < S; i++) begin : g_cos
      logic signed [CXW-1:0] xi, yi;
      logic signed [CZW-1:0] zi, ti;
      logic        [32:0]    dloni;
      logic        [31:0]    dlati;
      logic signed [25:0]    dalti;

      if (i == 0) begin : g_first
         assign xi    = $signed(gea_pkg::INV_GAIN_Q30);
         assign yi    = '0;
         assign zi    = p2_z_ff;
         assign dloni = p2_dlon_ff;
         assign dlati = p2_dlat_ff;
         assign dalti = p2_dalt_ff;
      end else begin : g_next
         assign xi    = cx_ff[i-1];
         assign yi    = cy_ff[i-1];
         assign zi    = cz_ff[i-1];
         assign dloni = cdlon_ff[i-1];
         assign dlati = cdlat_ff[i-1];
         assign dalti = cdalt_ff[i-1];
      end

      assign ti = gea_pkg::atan_q32(5'(i));

      always_ff @(posedge clock) begin
         if (en[C_BASE+i]) begin
            if (!zi[CZW-1]) begin
               cx_ff[i] <= xi - (yi >>> i);
               cy_ff[i] <= yi + (xi >>> i);
               cz_ff[i] <= zi - ti;
            end else begin
               cx_ff[i] <= xi + (yi >>> i);
               cy_ff[i] <= yi - (xi >>> i);
               cz_ff[i] <= zi + ti;
            end
            cdlon_ff[i] <= dloni;
            cdlat_ff[i] <= dlati;
            cdalt_ff[i] <= dalti;
         end
      end
   end

   // ---------------------------------------------------------------- ac: cosine magnitude
   logic        [31:0] ac_cos_ff;
   logic        [32:0] ac_dlon_ff;
   logic        [31:0] ac_dlat_ff;
   logic signed [25:0] ac_dalt_ff;
   logic signed [CXW-1:0] cos_last;

   assign cos_last = cx_ff[S-1];

   always_ff @(posedge clock) begin
      if (en[ACS]) begin
         ac_cos_ff  <= cos_last[CXW-1] ? 32'(-cos_last) : 32'(cos_last);
         ac_dlon_ff <= cdlon_ff[S-1];
         ac_dlat_ff <= cdlat_ff[S-1];
         ac_dalt_ff <= cdalt_ff[S-1];
      end
   end

   // ---------------------------------------------------------------- ax: scaled longitude difference
   logic        [34:0] ax_x_ff;
   logic        [31:0] ax_dlat_ff;
   logic signed [25:0] ax_dalt_ff;
   logic        [64:0] ax_prod;

   assign ax_prod = {32'd0, ac_dlon_ff} * {33'd0, ac_cos_ff};

   always_ff @(posedge clock) begin
      if (en[AXS]) begin
         ax_x_ff    <= 35'((ax_prod + 65'd536870912) >> 30);
         ax_dlat_ff <= ac_dlat_ff;
         ax_dalt_ff <= ac_dalt_ff;
      end
   end

   // ---------------------------------------------------------------- hk: range halving
   logic               hk_k_ff;
   logic        [31:0] hk_hx_ff;
   logic        [31:0] hk_hy_ff;
   logic signed [25:0] hk_dalt_ff;
   logic               k_in;

   assign k_in = (ax_x_ff >= 35'd2147483648) || ax_dlat_ff[31];

   always_ff @(posedge clock) begin
      if (en[HKS]) begin
         hk_k_ff    <= k_in;
         hk_hx_ff   <= 32'(ax_x_ff >> k_in);
         hk_hy_ff   <= ax_dlat_ff >> k_in;
         hk_dalt_ff <= ax_dalt_ff;
      end
   end

   // ---------------------------------------------------------------- sq / sum: squared hypotenuse
   logic        [63:0] sq_x_ff;
   logic        [63:0] sq_y_ff;
   logic               sq_k_ff;
   logic signed [25:0] sq_dalt_ff;

   always_ff @(posedge clock) begin
      if (en[SQS]) begin
         sq_x_ff    <= {32'd0, hk_hx_ff} * {32'd0, hk_hx_ff};
         sq_y_ff    <= {32'd0, hk_hy_ff} * {32'd0, hk_hy_ff};
         sq_k_ff    <= hk_k_ff;
         sq_dalt_ff <= hk_dalt_ff;
      end
   end

   logic        [63:0] sum_v_ff;
   logic               sum_k_ff;
   logic signed [25:0] sum_dalt_ff;

   always_ff @(posedge clock) begin
      if (en[SUMS]) begin
         sum_v_ff    <= sq_x_ff + sq_y_ff;
         sum_k_ff    <= sq_k_ff;
         sum_dalt_ff <= sq_dalt_ff;
      end
   end

   // ---------------------------------------------------------------- square root, one bit per stage
   logic        [63:0] rrem_ff  [32];
   logic        [31:0] rroot_ff [32];
   logic               rk_ff    [32];
   logic signed [25:0] rdalt_ff [32];

   for (genvar j = 0; j < 32; j++) begin : g_sqrt
      localparam int B = 31 - j;
      logic        [63:0] remi, cand;
      logic        [31:0] rooti;
      logic               ki;
      logic signed [25:0] dalti;

      if (j == 0) begin : g_first
         assign remi  = sum_v_ff;
         assign rooti = '0;
         assign ki    = sum_k_ff;
         assign dalti = sum_dalt_ff;
      end else begin : g_next
         assign remi  = rrem_ff[j-1];
         assign rooti = rroot_ff[j-1];
         assign ki    = rk_ff[j-1];
         assign dalti = rdalt_ff[j-1];
      end

      // (root + 2^b)^2 - root^2
      assign cand = ({32'd0, rooti} << (B + 1)) + (64'd1 << (2 * B));

      always_ff @(posedge clock) begin
         if (en[R_BASE+j]) begin
            if (remi >= cand) begin
               rrem_ff[j]  <= remi - cand;
               rroot_ff[j] <= rooti | (32'd1 << B);
            end else begin
               rrem_ff[j]  <= remi;
               rroot_ff[j] <= rooti;
            end
            rk_ff[j]    <= ki;
            rdalt_ff[j] <= dalti;
         end
      end
   end

   // ---------------------------------------------------------------- hh: hypotenuse
   logic        [33:0] hh_h_ff;
   logic               hh_hz_ff;
   logic signed [25:0] hh_dalt_ff;

   always_ff @(posedge clock) begin
      if (en[HHS]) begin
         hh_h_ff    <= {2'd0, rroot_ff[31]} << rk_ff[31];
         hh_hz_ff   <= (rroot_ff[31] == '0);
         hh_dalt_ff <= rdalt_ff[31];
      end
   end

   // ---------------------------------------------------------------- mp: metres and centimetres
   logic        [59:0] mp_dprod_ff;
   logic        [58:0] mp_xprod_ff;
   logic               mp_hz_ff;
   logic signed [25:0] mp_dalt_ff;

   always_ff @(posedge clock) begin
      if (en[MPS]) begin
         mp_dprod_ff <= {26'd0, hh_h_ff} * {34'd0, gea_pkg::KM_Q32};
         mp_xprod_ff <= {25'd0, hh_h_ff} * {34'd0, gea_pkg::KCM_Q24};
         mp_hz_ff    <= hh_hz_ff;
         mp_dalt_ff  <= hh_dalt_ff;
      end
   end

   // ---------------------------------------------------------------- dx: distance, vectoring inputs
   logic        [gea_pkg::DIST_W-1:0] dx_dist_ff;
   logic signed [AXW-1:0]             dx_x_ff;
   logic signed [AXW-1:0]             dx_y_ff;
   logic                              dx_hz_ff;
   logic signed [25:0]                dx_dalt_ff;
   logic        [27:0]                dist_in;
   logic        [25:0]                dalt_mag;

   assign dist_in  = 28'((mp_dprod_ff + 60'd2147483648) >> 32);
   assign dalt_mag = mp_dalt_ff[25] ? 26'(-mp_dalt_ff) : 26'(mp_dalt_ff);

   always_ff @(posedge clock) begin
      if (en[DXS]) begin
         dx_dist_ff <= (dist_in > {2'd0, gea_pkg::DIST_MAX}) ? gea_pkg::DIST_MAX
                                                             : 26'(dist_in);
         dx_x_ff    <= $signed({3'd0, mp_xprod_ff});
         dx_y_ff    <= $signed({12'd0, dalt_mag, 24'd0});
         dx_hz_ff   <= mp_hz_ff;
         dx_dalt_ff <= mp_dalt_ff;
      end
   end

   // ---------------------------------------------------------------- arctangent cordic (vectoring)
   logic signed [AXW-1:0]             axx_ff   [S];
   logic signed [AXW-1:0]             axy_ff   [S];
   logic signed [CZW-1:0]             az_ff    [S];
   logic        [gea_pkg::DIST_W-1:0] adist_ff [S];
   logic                              ahz_ff   [S];
   logic signed [25:0]                adalt_ff [S];

   for (genvar i = 0; i < S; i++) begin : g_atan
      logic signed [AXW-1:0]             xi, yi;
      logic signed [CZW-1:0]             zi, ti;
      logic        [gea_pkg::DIST_W-1:0] disti;
      logic                              hzi;
      logic signed [25:0]                dalti;

      if (i == 0) begin : g_first
         assign xi    = dx_x_ff;
         assign yi    = dx_y_ff;
         assign zi    = '0;
         assign disti = dx_dist_ff;
         assign hzi   = dx_hz_ff;
         assign dalti = dx_dalt_ff;
      end else begin : g_next
         assign xi    = axx_ff[i-1];
         assign yi    = axy_ff[i-1];
         assign zi    = az_ff[i-1];
         assign disti = adist_ff[i-1];
         assign hzi   = ahz_ff[i-1];
         assign dalti = adalt_ff[i-1];
      end

      assign ti = gea_pkg::atan_q32(5'(i));

      always_ff @(posedge clock) begin
         if (en[A_BASE+i]) begin
            if (!yi[AXW-1]) begin
               axx_ff[i] <= xi + (yi >>> i);
               axy_ff[i] <= yi - (xi >>> i);
               az_ff[i]  <= zi + ti;
            end else begin
               axx_ff[i] <= xi - (yi >>> i);
               axy_ff[i] <= yi + (xi >>> i);
               az_ff[i]  <= zi - ti;
            end
            adist_ff[i] <= disti;
            ahz_ff[i]   <= hzi;
            adalt_ff[i] <= dalti;
         end
      end
   end

   // ---------------------------------------------------------------- zp: radians to 0.01 degree
   logic        [63:0]                zp_prod_ff;
   logic                              zp_zneg_ff;
   logic        [gea_pkg::DIST_W-1:0] zp_dist_ff;
   logic                              zp_hz_ff;
   logic signed [25:0]                zp_dalt_ff;
   logic signed [CZW-1:0]             z_last;
   logic        [34:0]                z_mag;

   assign z_last = az_ff[S-1];
   assign z_mag  = z_last[CZW-1] ? 35'(-z_last) : 35'(z_last);

   always_ff @(posedge clock) begin
      if (en[ZPS]) begin
         zp_prod_ff <= {29'd0, z_mag} * {35'd0, gea_pkg::DEG100_Q16};
         zp_zneg_ff <= z_last[CZW-1];
         zp_dist_ff <= adist_ff[S-1];
         zp_hz_ff   <= ahz_ff[S-1];
         zp_dalt_ff <= adalt_ff[S-1];
      end
   end

   // ---------------------------------------------------------------- out: special cases, sign
   logic signed [gea_pkg::TILT_W-1:0] out_tilt_ff;
   logic        [gea_pkg::DIST_W-1:0] out_dist_ff;
   logic        [15:0]                ang_rnd;
   logic        [gea_pkg::TILT_W-1:0] ang_mag;
   logic signed [gea_pkg::TILT_W-1:0] tilt_in;

   assign ang_rnd = 16'((zp_prod_ff + 64'd140737488355328) >> 48);

   always_comb begin
      // equal altitudes win over a zero hypotenuse, which wins over the cordic angle
      priority if (zp_dalt_ff == '0) begin
         ang_mag = '0;
      end else if (zp_hz_ff) begin
         ang_mag = gea_pkg::ANGLE_MAX;
      end else if (zp_zneg_ff) begin
         ang_mag = '0;
      end else if (ang_rnd > {1'b0, gea_pkg::ANGLE_MAX}) begin
         ang_mag = gea_pkg::ANGLE_MAX;
      end else begin
         ang_mag = 15'(ang_rnd);
      end
      tilt_in = zp_dalt_ff[25] ? -$signed(ang_mag) : $signed(ang_mag);
   end

   always_ff @(posedge clock) begin
      if (en[OUTS]) begin
         out_tilt_ff <= tilt_in;
         out_dist_ff <= zp_dist_ff;
      end
   end

   assign rsp.valid           = v_ff[NS-1];
   assign rsp.tilt_angle      = out_tilt_ff;
   assign rsp.ground_distance = out_dist_ff;

endmodule

FILE: tb/gps_elevation_angle_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_elevation_angle_tb
// drives point pairs into the elevation angle pipeline and checks each
// result against a bit-exact predictor; a directed table comes first, then
// random pairs, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module gps_elevation_angle_tb;

   localparam int N_RANDOM   = 1630;
   localparam int QUIET_LO   = 900;    // no idling on either side in this window
   localparam int QUIET_HI   = 1150;
   localparam int HOLD_AT    = 500;    // receiver blocks for a long stretch here
   localparam int HOLD_LEN   = 400;
   localparam int DRAIN_WAIT = 45 + 2 * gea_pkg::CORDIC_STAGES_DEFAULT + 20;

   // fixed-point constants of the predictor
   localparam longint PI_K      = 64'd13493037705;
   localparam longint HALF_PI_K = 64'd6746518852;
   localparam longint QPI_K     = 64'd3373259426;
   localparam longint unsigned LAT_RAD_K = 64'd1006113814;
   localparam longint INV_GAIN_K = 64'd652032874;
   localparam longint unsigned KM_K   = 64'd47757857;
   localparam longint unsigned KCM_K  = 64'd18655413;
   localparam longint unsigned DEG_K  = 64'd375493621;
   localparam longint unsigned DMAX_K = 64'd45000000;
   localparam longint AMAX_K = 64'd9000;

   typedef struct packed {
      logic signed [gea_pkg::LAT_W-1:0] lat_a;
      logic signed [gea_pkg::LON_W-1:0] lon_a;
      logic signed [gea_pkg::ALT_W-1:0] alt_a;
      logic signed [gea_pkg::LAT_W-1:0] lat_b;
      logic signed [gea_pkg::LON_W-1:0] lon_b;
      logic signed [gea_pkg::ALT_W-1:0] alt_b;
   } pair_type;

   typedef struct packed {
      logic signed [gea_pkg::TILT_W-1:0] tilt;
      logic [gea_pkg::DIST_W-1:0]        gdist;
   } climb_type;

   typedef struct {
      pair_type  pair;
      bit        known;      // expected result typed in the row
      climb_type res;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gea_req_if req_if ();
   gea_rsp_if rsp_if ();

   gps_elevation_angle u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always #5 clock = ~clock;

   climb_type pending_climbs[$];
   climb_type typed_climbs[$];      // typed expectation, parallel to pending
   bit        typed_flags[$];
   row_type   pair_table[$];
   int     fail_count = 0;
   int     sent_count = 0;
   int     rsp_count  = 0;
   int     typed_hits = 0;
   int     hold_cycles = 0;
   bit     hold_done = 1'b0;

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------
   function automatic longint unsigned mag64(longint v);
      return v < 0 ? 64'd0 - longint'(v) : v;
   endfunction

   // arctangent of 2^-i in q32 from its power series in q62
   function automatic longint arctan_step(int i);
      longint acc;
      longint term;
      acc = 0;
      if (i == 0) return QPI_K;
      for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
         term = longint'((64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1));
         if (k & 1) acc -= term;
         else acc += term;
      end
      return (acc + (64'd1 << 29)) >>> 30;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // cosine of the mean latitude in q30, from the latitude sum
   function automatic longint mean_lat_cos(longint latsum);
      longint z, x, y, sx, sy, t;
      bit     neg;
      z = longint'((mag64(latsum) * LAT_RAD_K + (64'd1 << 27)) >> 28);
      x = INV_GAIN_K;
      y = 0;
      neg = 1'b0;
      if (z > HALF_PI_K) begin
         z = PI_K - z;
         neg = 1'b1;
      end
      for (int i = 0; i < gea_pkg::CORDIC_STAGES_DEFAULT; i++) begin
         sx = y >>> i;
         sy = x >>> i;
         t = arctan_step(i);
         if (z >= 0) begin
            x -= sx; y += sy; z -= t;
         end else begin
            x += sx; y -= sy; z += t;
         end
      end
      return neg ? -x : x;
   endfunction

   // vectoring arctangent, hundredths of a degree, clipped at 9000
   function automatic longint climb_deg100(longint x, longint y);
      longint z, sx, sy, t;
      longint unsigned a;
      z = 0;
      for (int i = 0; i < gea_pkg::CORDIC_STAGES_DEFAULT; i++) begin
         sx = y >>> i;
         sy = x >>> i;
         t = arctan_step(i);
         if (y >= 0) begin
            x += sx; y -= sy; z += t;
         end else begin
            x -= sx; y += sy; z -= t;
         end
      end
      a = (mag64(z) * DEG_K + (64'd1 << 47)) >> 48;
      if (a > AMAX_K) a = AMAX_K;
      return z < 0 ? -longint'(a) : longint'(a);
   endfunction

   function automatic climb_type predict_climb(pair_type p);
      longint unsigned ac, ax, ay, hx, hy, h, gdist_m;
      longint dalt, ang;
      int sh;
      climb_type r;
      ac = mag64(mean_lat_cos(longint'(p.lat_a) + longint'(p.lat_b)));
      ax = (mag64(longint'(p.lon_b) - longint'(p.lon_a)) * ac + (64'd1 << 29)) >> 30;
      ay = mag64(longint'(p.lat_b) - longint'(p.lat_a));
      // halve both legs when either leaves 31 bits
      sh = (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) ? 1 : 0;
      hx = ax >> sh;
      hy = ay >> sh;
      h = root_floor(hx * hx + hy * hy) << sh;
      gdist_m = (h * KM_K + (64'd1 << 31)) >> 32;
      dalt = longint'(p.alt_b) - longint'(p.alt_a);
      if (gdist_m > DMAX_K) gdist_m = DMAX_K;
      if (dalt == 0) ang = 0;
      else if (h == 0) ang = AMAX_K;
      else begin
         ang = climb_deg100(longint'(h * KCM_K), longint'(mag64(dalt) << 24));
         if (ang < 0) ang = 0;
      end
      if (dalt < 0) ang = -ang;
      r.tilt = ang[gea_pkg::TILT_W-1:0];
      r.gdist = gdist_m[gea_pkg::DIST_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   function automatic pair_type mk_pair(longint la, longint oa, longint aa,
                                        longint lb, longint ob, longint ab);
      pair_type p;
      p.lat_a = la[gea_pkg::LAT_W-1:0];
      p.lon_a = oa[gea_pkg::LON_W-1:0];
      p.alt_a = aa[gea_pkg::ALT_W-1:0];
      p.lat_b = lb[gea_pkg::LAT_W-1:0];
      p.lon_b = ob[gea_pkg::LON_W-1:0];
      p.alt_b = ab[gea_pkg::ALT_W-1:0];
      return p;
   endfunction

   task automatic add_row(pair_type p, bit known, longint tilt, longint gdist);
      row_type r;
      r.pair = p;
      r.known = known;
      r.res.tilt = tilt[gea_pkg::TILT_W-1:0];
      r.res.gdist = gdist[gea_pkg::DIST_W-1:0];
      pair_table.push_back(r);
   endtask

   function automatic longint rand_range(longint lo, longint hi);
      longint unsigned span;
      span = hi - lo + 1;
      return lo + longint'(({$urandom, $urandom}) % span);
   endfunction

   // mostly realistic pairs: nearby points, sometimes far, sometimes raw bits
   function automatic pair_type rand_pair();
      pair_type p;
      logic [191:0] raw;
      int mode;
      longint la, oa, aa, ab;
      mode = $urandom_range(99);
      if (mode < 8) begin
         raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         p = raw[$bits(pair_type)-1:0];
         return p;
      end
      la = rand_range(-900000000, 900000000);
      oa = rand_range(-1800000000, 1800000000);
      aa = rand_range(-100000, 10000000);
      if (mode < 60) begin
         // local hop: under a kilometre, modest climb
         p = mk_pair(la, oa, aa, la + rand_range(-50000, 50000),
                     oa + rand_range(-50000, 50000), aa + rand_range(-20000, 20000));
         if (la > 899000000 || la < -899000000) p.lat_b = p.lat_a;
      end else if (mode < 70) begin
         // tiny ground step, steep climb
         p = mk_pair(la, oa, aa, la + rand_range(-3, 3), oa + rand_range(-3, 3),
                     rand_range(-100000, 10000000));
      end else if (mode < 78) begin
         ab = aa;
         if ($urandom_range(1)) ab = aa + rand_range(-5, 5);
         p = mk_pair(la, oa, aa, la, oa, ab);
      end else begin
         p = mk_pair(la, oa, aa, rand_range(-900000000, 900000000),
                     rand_range(-1800000000, 1800000000), rand_range(-100000, 10000000));
         if ($urandom_range(3) == 0) p.alt_b = p.alt_a;
      end
      return p;
   endfunction

   initial begin
      // all zero, and same ground point with a climb or a drop
      add_row(mk_pair(0, 0, 0, 0, 0, 0), 1, 0, 0);
      add_row(mk_pair(123456789, -98765432, 1000, 123456789, -98765432, 5000), 1, 9000, 0);
      add_row(mk_pair(-45000000, 1700000000, 5000, -45000000, 1700000000, -100), 1, -9000, 0);
      add_row(mk_pair(900000000, 1800000000, 10000000, 900000000, 1800000000, -100000),
              1, -9000, 0);
      // widest longitude span at the equator saturates the distance
      add_row(mk_pair(0, -64'sd2147483648, 0, 0, 2147483647, 0), 1, 0, 45000000);
      add_row(mk_pair(0, -64'sd2147483648, 7, 0, 2147483647, 7), 1, 0, 45000000);
      // field extremes, checked by the predictor
      add_row(mk_pair(-900000000, -1800000000, -100000, 900000000, 1800000000, 10000000),
              0, 0, 0);
      add_row(mk_pair(900000000, 1800000000, 10000000, -900000000, -1800000000, -100000),
              0, 0, 0);
      add_row(mk_pair(-1073741824, -64'sd2147483648, -16777216, 1073741823, 2147483647,
                      16777215), 0, 0, 0);
      add_row(mk_pair(1073741823, 2147483647, 16777215, 1073741823, -64'sd2147483648,
                      -16777216), 0, 0, 0);
      add_row(mk_pair(-1073741824, 0, 0, -1073741824, 1000, 10), 0, 0, 0);
      // mean latitude near the pole, below the fold of the cosine
      add_row(mk_pair(800000000, 0, 0, 900000000, 100000000, 100), 0, 0, 0);
      add_row(mk_pair(-850000000, 5, 0, -900000000, 100000, -3000), 0, 0, 0);
      // steep but nonvertical, near-flat, overshoot region
      add_row(mk_pair(0, 0, 0, 1, 0, 10000000), 0, 0, 0);
      add_row(mk_pair(0, 0, 0, 0, 1, -16777216), 0, 0, 0);
      add_row(mk_pair(0, 0, 0, 900000000, 0, 1), 0, 0, 0);
      add_row(mk_pair(0, 0, 0, 0, 1000, 1), 0, 0, 0);
      add_row(mk_pair(473000000, 85000000, 50000, 473001000, 85002000, 52000), 0, 0, 0);
   end

   // sender: drives at the falling edge, waits for the transfer at the rising edge
   initial begin
      row_type r;
      int      total;
      req_if.valid <= 1'b0;
      req_if.lat_a <= '0; req_if.lon_a <= '0; req_if.alt_a <= '0;
      req_if.lat_b <= '0; req_if.lon_b <= '0; req_if.alt_b <= '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      total = pair_table.size() + N_RANDOM;
      for (int n = 0; n < total; n++) begin
         if (n < pair_table.size()) begin
            r = pair_table[n];
         end else begin
            r.pair = rand_pair();
            r.known = 1'b0;
         end
         // random idle cycles, none inside the quiet window
         while (!(n >= QUIET_LO && n < QUIET_HI) && $urandom_range(99) < 37) begin
            req_if.valid <= 1'b0;
            @(negedge clock);
         end
         req_if.valid <= 1'b1;
         req_if.lat_a <= r.pair.lat_a; req_if.lon_a <= r.pair.lon_a;
         req_if.alt_a <= r.pair.alt_a; req_if.lat_b <= r.pair.lat_b;
         req_if.lon_b <= r.pair.lon_b; req_if.alt_b <= r.pair.alt_b;
         typed_flags.push_back(r.known);
         typed_climbs.push_back(r.res);
         do @(posedge clock); while (!req_if.ready);
         @(negedge clock);
      end
      req_if.valid <= 1'b0;
   end

   // receiver: random stalls, one long hold-off while the sender keeps offering
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && sent_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_cycles = HOLD_LEN;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_if.ready <= 1'b0;
         end else if (sent_count >= QUIET_LO && sent_count < QUIET_HI) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= 37);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor and checker
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      climb_type want, got, typed;
      bit        known;
      if (!reset && req_if.valid && req_if.ready) begin
         pending_climbs.push_back(predict_climb({req_if.lat_a, req_if.lon_a, req_if.alt_a,
                                                 req_if.lat_b, req_if.lon_b, req_if.alt_b}));
         sent_count++;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.tilt = rsp_if.tilt_angle;
         got.gdist = rsp_if.ground_distance;
         if (pending_climbs.size() == 0) begin
            $error("result transfer with nothing expected: tilt %0d dist %0d",
                   got.tilt, got.gdist);
            fail_count++;
         end else begin
            want = pending_climbs.pop_front();
            known = typed_flags.pop_front();
            typed = typed_climbs.pop_front();
            // typed rows also cross-check the predictor itself
            if (known) begin
               typed_hits++;
               if (typed != want) begin
                  $error("predictor disagrees with table row: tilt %0d/%0d dist %0d/%0d",
                         typed.tilt, want.tilt, typed.gdist, want.gdist);
                  fail_count++;
               end
               want = typed;
            end
            if (got.tilt !== want.tilt) begin
               $error("tilt_angle mismatch: expected %0d, actual %0d", want.tilt, got.tilt);
               fail_count++;
            end
            if (got.gdist !== want.gdist) begin
               $error("ground_distance mismatch: expected %0d, actual %0d",
                      want.gdist, got.gdist);
               fail_count++;
            end
         end
         rsp_count++;
      end
   end

   // end of run
   initial begin
      wait (sent_count == pair_table.size() + N_RANDOM && pair_table.size() > 0);
      while (pending_climbs.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d point pairs (%0d with typed results), %0d results checked,",
               sent_count, typed_hits, rsp_count);
      $display("random gaps and stalls, one %0d-cycle receiver hold-off", HOLD_LEN);
      if (fail_count == 0 && pending_climbs.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

endmodule
